### hdl/row_peak_thinning_unit_macros.svh
// Assertion macros shared by the row peak thinning RTL.
`ifndef ROW_PEAK_THINNING_UNIT_MACROS_SVH
`define ROW_PEAK_THINNING_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define RPT_ASSERT_NOW(name, cond, conseq) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error("row peak thinning check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define RPT_ASSERT_NEXT(name, cond, conseq) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error("row peak thinning check failed");

`endif

### hdl/rpt_pkg.sv
// Package with the types and constants of the row peak thinning unit.
`timescale 1ns / 1ps

package rpt_pkg;

   localparam int PIXEL_WIDTH = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam logic [PIXEL_WIDTH-1:0] THRESHOLD_RESET = 8'd20;

   typedef logic [PIXEL_WIDTH-1:0] pixel_type;

   typedef struct packed {
      logic      row_end;
      pixel_type pixel;
   } entry_type;

endpackage

### hdl/row_peak_thinning_unit.sv
// Top level of the row peak thinning unit: per-pixel decision and result queue.
`timescale 1ns / 1ps
`include "row_peak_thinning_unit_macros.svh"

// The unit takes one pixel per clock while the result queue has room and
// keeps only rising peaks above the threshold within each row, holding one
// result back so that a new maximum can still clear it. Every accepted pixel
// is decided in the cycle of its transfer and its results go into a small
// result queue of QUEUE_DEPTH entries; a pixel that ends a row gives up to
// two results at once. The input is ready while the queue holds at most
// QUEUE_DEPTH - 2 results, so with a ready consumer the unit sustains one
// pixel per clock. The threshold is written through the csr channel while
// the unit is idle; the user must keep to this, the unit does not enforce it.
module row_peak_thinning_unit
   import rpt_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] pixel
   input  logic       req_tlast,  // row_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [7:0] out_pixel
   output logic       rsp_tlast,  // out_row_end
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data    // [7:0] threshold
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   pixel_type threshold_ff;
   pixel_type held_value_ff, held_value_in;
   logic      held_valid_ff, held_valid_in;
   pixel_type previous_ff, previous_in;
   pixel_type maximum_ff, maximum_in;
   logic      row_start_ff, row_start_in;

   entry_type         queue_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   logic      req_accept, rsp_accept;
   logic      push_held, push_cur;
   pixel_type pix, cur, held_out;
   logic      clear_held;
   logic      above, below, above_max, below_max, prev_nonzero;
   entry_type held_entry, cur_entry;

   assign csr_ready  = 1'b1;
   assign req_tready = (count_ff <= CW'(QUEUE_DEPTH - 2));
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = queue_ff[rd_ptr_ff].pixel;
   assign rsp_tlast  = queue_ff[rd_ptr_ff].row_end;

   assign pix          = req_tdata;
   assign above        = pix > threshold_ff;
   assign below        = pix < threshold_ff;
   assign above_max    = pix > maximum_ff;
   assign below_max    = pix < maximum_ff;
   assign prev_nonzero = previous_ff != '0;

   always_comb begin
      cur         = '0;
      clear_held  = 1'b0;
      previous_in = previous_ff;
      maximum_in  = maximum_ff;
      if (row_start_ff) begin
         previous_in = above ? pix : '0;
         maximum_in  = above ? pix : '0;
         cur         = above ? pix : '0;
      end else if (above && above_max) begin
         cur         = pix;
         clear_held  = prev_nonzero;
         previous_in = pix;
         maximum_in  = pix;
      end else if (above && below_max && prev_nonzero) begin
         previous_in = pix;
      end else if (below && prev_nonzero) begin
         previous_in = '0;
         maximum_in  = '0;
      end

      held_out = clear_held ? '0 : held_value_ff;

      if (req_tlast) begin
         held_value_in = '0;
         held_valid_in = 1'b0;
         row_start_in  = 1'b1;
         previous_in   = '0;
         maximum_in    = '0;
      end else begin
         held_value_in = cur;
         held_valid_in = 1'b1;
         row_start_in  = 1'b0;
      end
   end

   assign push_held  = req_accept && held_valid_ff;
   assign push_cur   = req_accept && req_tlast;
   assign held_entry = '{row_end: 1'b0, pixel: held_out};
   assign cur_entry  = '{row_end: 1'b1, pixel: cur};

   always_comb begin
      unique case ({push_held, push_cur})
         2'b11:   wr_ptr_in = ptr_next(ptr_next(wr_ptr_ff));
         2'b10,
         2'b01:   wr_ptr_in = ptr_next(wr_ptr_ff);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = rsp_accept ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push_held) + CW'(push_cur) - CW'(rsp_accept);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= THRESHOLD_RESET;
         held_value_ff <= '0;
         held_valid_ff <= 1'b0;
         previous_ff   <= '0;
         maximum_ff    <= '0;
         row_start_ff  <= 1'b1;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (csr_valid) begin
            threshold_ff <= csr_data;
         end
         if (req_accept) begin
            held_value_ff <= held_value_in;
            held_valid_ff <= held_valid_in;
            previous_ff   <= previous_in;
            maximum_ff    <= maximum_in;
            row_start_ff  <= row_start_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_held) begin
         queue_ff[wr_ptr_ff] <= held_entry;
      end
      if (push_cur) begin
         queue_ff[push_held ? ptr_next(wr_ptr_ff) : wr_ptr_ff] <= cur_entry;
      end
   end

   `RPT_ASSERT_NOW(a_room_on_accept, req_accept, count_ff <= CW'(QUEUE_DEPTH - 2))
   `RPT_ASSERT_NEXT(a_row_end_restarts, req_accept && req_tlast, row_start_ff && !held_valid_ff)
   `RPT_ASSERT_NOW(a_held_not_at_start, held_valid_ff, !row_start_ff)
   `RPT_ASSERT_NOW(a_start_state_clear, row_start_ff, previous_ff == '0 && maximum_ff == '0)

endmodule
